FILE: rtl/qppg_pkg.sv
package qppg_pkg;

  // default configuration
  localparam int MAX_STEPS_DEF  = 63;
  localparam int ANGLE_BITS_DEF = 16;

  // fixed-point formats
  localparam int TRIG_BITS    = 30;
  localparam int T_BITS       = 24;
  localparam int CORDIC_ITERS = 24;
  localparam int CORDIC_W     = 34;
  localparam int ACC_W        = 40;
  localparam int MB_W         = 32;
  localparam int PROD_W       = ACC_W + MB_W;
  localparam int CNT_W        = 5;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

  // pipelined multiply schedules
  localparam int SCALE_LAST  = 4;
  localparam int HORNER_LAST = 10;

  // polynomial coefficient weights
  localparam int A3_D  = 10;
  localparam int A3_V0 = -6;
  localparam int A3_V1 = -4;
  localparam int A4_D  = -15;
  localparam int A4_V0 = 8;
  localparam int A4_V1 = 7;
  localparam int A5_D  = 6;
  localparam int A5_V0 = -3;
  localparam int A5_V1 = -3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CSTEP,
    OP_CSWAP,
    OP_CSTORE,
    OP_SCALE,
    OP_COEF,
    OP_DIV,
    OP_HORNER,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic is_last;
  } status_t;

  // arctangent table, units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/quintic_path_point_generator.sv
// Quintic path point generator: one segment (end points, headings, slope
// magnitudes, step count) in, steps or steps+1 points out in index order
// (a step count of zero counts as one), the final one flagged, at most 64
// points per segment. A segment's setup is two 24-step cordic runs with a
// store step after each, the four slope products on the shared multiplier,
// one coefficient step and a 25-step bit-serial reciprocal of the step
// count; each point then takes ten Horner products through the single
// shared multiplier plus the emit step, which waits while the output is
// held. The input is taken only between segments; a finished point waits in
// the output register while the next one is computed.
module quintic_path_point_generator #(
  parameter int MAX_STEPS  = qppg_pkg::MAX_STEPS_DEF,
  parameter int ANGLE_BITS = qppg_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic [15:0]        start_heading,
  input  logic [15:0]        end_heading,
  input  logic signed [31:0] start_slope,
  input  logic signed [31:0] end_slope,
  input  logic [5:0]         steps,
  input  logic               include_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [5:0]         point_index,
  output logic               last_point
);

  qppg_pkg::cmd_t    cmd;
  qppg_pkg::status_t st;

  // sequencer
  qppg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // arithmetic
  qppg_datapath #(
    .MAX_STEPS  (MAX_STEPS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .st            (st),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .start_heading (start_heading),
    .end_heading   (end_heading),
    .start_slope   (start_slope),
    .end_slope     (end_slope),
    .steps         (steps),
    .include_end   (include_end),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_index   (point_index),
    .last_point    (last_point)
  );

endmodule

FILE: rtl/qppg_ctrl.sv
module qppg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  qppg_pkg::status_t st,
  output qppg_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CORD   = 8'b0000_0010,
    S_CSTORE = 8'b0000_0100,
    S_SCALE  = 8'b0000_1000,
    S_COEF   = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_HORNER = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t                     state, state_next;
  logic [qppg_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                       sel, sel_next;
  logic                       out_load;
  logic                       out_valid_next;

  assign in_stall = (state != S_IDLE);

  // sequencing of the segment work
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    out_load   = 1'b0;
    cmd.op     = qppg_pkg::OP_NONE;
    cmd.cnt    = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = qppg_pkg::OP_LOAD;
          state_next = S_CORD;
          cnt_next   = '0;
          sel_next   = 1'b0;
        end
      end
      S_CORD: begin
        cmd.op = qppg_pkg::OP_CSTEP;
        if (cnt == qppg_pkg::CNT_W'(qppg_pkg::CORDIC_ITERS - 1)) begin
          state_next = S_CSTORE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CSTORE: begin
        if (!sel) begin
          cmd.op     = qppg_pkg::OP_CSWAP;
          sel_next   = 1'b1;
          state_next = S_CORD;
        end else begin
          cmd.op     = qppg_pkg::OP_CSTORE;
          state_next = S_SCALE;
        end
        cnt_next = '0;
      end
      S_SCALE: begin
        cmd.op = qppg_pkg::OP_SCALE;
        if (cnt == qppg_pkg::CNT_W'(qppg_pkg::SCALE_LAST)) begin
          state_next = S_COEF;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_COEF: begin
        cmd.op     = qppg_pkg::OP_COEF;
        state_next = S_DIV;
        cnt_next   = '0;
      end
      S_DIV: begin
        cmd.op = qppg_pkg::OP_DIV;
        if (cnt == qppg_pkg::CNT_W'(qppg_pkg::T_BITS)) begin
          state_next = S_HORNER;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_HORNER: begin
        cmd.op = qppg_pkg::OP_HORNER;
        if (cnt == qppg_pkg::CNT_W'(qppg_pkg::HORNER_LAST)) begin
          state_next = S_EMIT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          cmd.op     = qppg_pkg::OP_EMIT;
          state_next = st.is_last ? S_IDLE : S_HORNER;
        end
        cnt_next = '0;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_CORD && cnt == '0))
    else $error("segment start did not enter the cordic phase");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && out_stall) |=> (state == S_EMIT))
    else $error("point emitted over a held output");

  a_horner_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_HORNER && cnt == qppg_pkg::CNT_W'(qppg_pkg::HORNER_LAST))
      |=> (state == S_EMIT))
    else $error("evaluation did not lead to emit");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_load && st.is_last) |=> (state == S_IDLE && out_valid))
    else $error("segment did not finish after its last point");

endmodule

FILE: rtl/qppg_datapath.sv
module qppg_datapath #(
  parameter int MAX_STEPS  = qppg_pkg::MAX_STEPS_DEF,
  parameter int ANGLE_BITS = qppg_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  qppg_pkg::cmd_t     cmd,
  output qppg_pkg::status_t  st,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic [15:0]        start_heading,
  input  logic [15:0]        end_heading,
  input  logic signed [31:0] start_slope,
  input  logic signed [31:0] end_slope,
  input  logic [5:0]         steps,
  input  logic               include_end,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [5:0]         point_index,
  output logic               last_point
);

  localparam int SW   = $clog2(MAX_STEPS + 1);
  localparam int CW   = (SW > 6) ? SW : 6;
  localparam int AW   = qppg_pkg::ACC_W;
  localparam int XW   = qppg_pkg::CORDIC_W;
  localparam int PW   = qppg_pkg::PROD_W;
  localparam int TW   = qppg_pkg::T_BITS + 1;
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // latched segment
  logic signed [AW-1:0] p0x, p0y, p1x, p1y;
  logic signed [31:0]   ss, es;
  logic [15:0]          eh;
  logic [SW-1:0]        n, last;

  // cordic
  logic signed [XW-1:0] cx, cy, cz;
  logic [1:0]           cq;
  logic signed [31:0]   s0, c0, s1, c1;

  // slope parts and coefficients
  logic signed [AW-1:0] vx0, vy0, vx1, vy1;
  logic signed [AW-1:0] a3x, a4x, a5x, a3y, a4y, a5y;
  logic signed [AW-1:0] accx, accy;

  // t generation
  logic [SW-1:0]        dr, r;
  logic [TW-1:0]        dq, t;
  logic [SW-1:0]        i;

  logic signed [PW-1:0] prod;

  // saturated step count and last index
  logic [CW-1:0] steps_w, idx_w;
  logic [SW-1:0] n_in, last_in;
  always_comb begin
    steps_w = CW'(steps);
    if (steps == 6'd0) begin
      n_in = SW'(1);
    end else if (steps_w > CW'(MAX_STEPS)) begin
      n_in = SW'(MAX_STEPS);
    end else begin
      n_in = steps_w[SW-1:0];
    end
    last_in = include_end ? n_in : n_in - 1'b1;
    idx_w   = CW'(i);
  end

  // cordic start: quadrant reduction of the selected heading
  logic [15:0]          hsel;
  logic [31:0]          ang, ang_rnd, ang_u;
  logic [1:0]           q_in;
  logic signed [XW-1:0] z_in;
  always_comb begin
    hsel    = (cmd.op == qppg_pkg::OP_LOAD) ? start_heading : eh;
    ang     = (({16'b0, hsel}) & ANG_MASK) << (32 - ANGLE_BITS);
    ang_rnd = ang + 32'h2000_0000;
    q_in    = ang_rnd[31:30];
    ang_u   = ang - {q_in, 30'b0};
    z_in    = XW'($signed(ang_u));
  end

  // one rotation step
  logic signed [XW-1:0] dxs, dys, atn, nx, ny, nz;
  always_comb begin
    dxs = cy >>> cmd.cnt;
    dys = cx >>> cmd.cnt;
    atn = XW'($signed({1'b0, qppg_pkg::atan_turn(cmd.cnt)}));
    if (!cz[XW-1]) begin
      nx = cx - dxs;
      ny = cy + dys;
      nz = cz - atn;
    end else begin
      nx = cx + dxs;
      ny = cy - dys;
      nz = cz + atn;
    end
  end

  // quadrant map to sine and cosine
  logic signed [XW-1:0] sin_m, cos_m;
  always_comb begin
    case (cq)
      2'd0: begin
        cos_m = cx;
        sin_m = cy;
      end
      2'd1: begin
        cos_m = -cy;
        sin_m = cx;
      end
      2'd2: begin
        cos_m = -cx;
        sin_m = -cy;
      end
      default: begin
        cos_m = cy;
        sin_m = -cx;
      end
    endcase
  end

  // multiply schedule: issue at cnt, write back the issue of cnt-1
  logic [qppg_pkg::CNT_W-1:0] wj;
  logic [2:0]                 wstage;
  logic                       mul_en, wb_en;
  logic signed [AW-1:0]       ma;
  logic signed [qppg_pkg::MB_W-1:0] mb;
  always_comb begin
    wj     = cmd.cnt - 1'b1;
    wstage = wj[3:1];
    mul_en = 1'b0;
    wb_en  = 1'b0;
    ma     = '0;
    mb     = '0;
    if (cmd.op == qppg_pkg::OP_SCALE) begin
      mul_en = (cmd.cnt < qppg_pkg::CNT_W'(qppg_pkg::SCALE_LAST));
      wb_en  = (cmd.cnt != '0);
      ma     = AW'(cmd.cnt[1] ? es : ss);
      case (cmd.cnt[1:0])
        2'd0:    mb = s0;
        2'd1:    mb = c0;
        2'd2:    mb = s1;
        default: mb = c1;
      endcase
    end else if (cmd.op == qppg_pkg::OP_HORNER) begin
      mul_en = (cmd.cnt < qppg_pkg::CNT_W'(qppg_pkg::HORNER_LAST));
      wb_en  = (cmd.cnt != '0);
      ma     = cmd.cnt[0] ? accy : accx;
      mb     = qppg_pkg::MB_W'(t);
    end
  end

  // rounded product
  logic signed [PW-1:0] rnd30, rnd24;
  logic signed [AW-1:0] pr30, pr24;
  always_comb begin
    rnd30 = (prod + (PW'(1) <<< (qppg_pkg::TRIG_BITS - 1))) >>> qppg_pkg::TRIG_BITS;
    rnd24 = (prod + (PW'(1) <<< (qppg_pkg::T_BITS - 1))) >>> qppg_pkg::T_BITS;
    pr30  = rnd30[AW-1:0];
    pr24  = rnd24[AW-1:0];
  end

  // horner addend for the write-back stage
  logic signed [AW-1:0] addx, addy;
  always_comb begin
    case (wstage)
      3'd0: begin
        addx = a4x;
        addy = a4y;
      end
      3'd1: begin
        addx = a3x;
        addy = a3y;
      end
      3'd3: begin
        addx = vx0;
        addy = vy0;
      end
      3'd4: begin
        addx = p0x;
        addy = p0y;
      end
      default: begin
        addx = '0;
        addy = '0;
      end
    endcase
  end

  // divider step for 2^T / n
  logic [SW:0] dsh;
  logic        dge;
  always_comb begin
    dsh = {dr, (cmd.cnt == '0)};
    dge = (dsh >= {1'b0, n});
  end

  // next t and remainder
  logic [SW:0] rsum;
  logic        rge;
  always_comb begin
    rsum = {1'b0, r} + {1'b0, dr};
    rge  = (rsum >= {1'b0, n});
  end

  // coefficients
  logic signed [AW-1:0] dx, dy;
  always_comb begin
    dx = p1x - p0x;
    dy = p1y - p0y;
  end

  // output saturation
  localparam logic signed [AW-1:0] SAT_HI = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] SAT_LO = -AW'(64'sd2147483648);
  logic signed [AW-1:0] satx, saty;
  always_comb begin
    satx = (accx > SAT_HI) ? SAT_HI : ((accx < SAT_LO) ? SAT_LO : accx);
    saty = (accy > SAT_HI) ? SAT_HI : ((accy < SAT_LO) ? SAT_LO : accy);
  end

  assign st.is_last = (i == last);

  // shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PW'(ma) * PW'(mb);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      qppg_pkg::OP_LOAD: begin
        p0x  <= AW'(start_x);
        p0y  <= AW'(start_y);
        p1x  <= AW'(end_x);
        p1y  <= AW'(end_y);
        ss   <= start_slope;
        es   <= end_slope;
        eh   <= end_heading;
        n    <= n_in;
        last <= last_in;
        cx   <= qppg_pkg::CORDIC_GAIN_INV;
        cy   <= '0;
        cz   <= z_in;
        cq   <= q_in;
      end
      qppg_pkg::OP_CSTEP: begin
        cx <= nx;
        cy <= ny;
        cz <= nz;
      end
      qppg_pkg::OP_CSWAP: begin
        s0 <= sin_m[31:0];
        c0 <= cos_m[31:0];
        cx <= qppg_pkg::CORDIC_GAIN_INV;
        cy <= '0;
        cz <= z_in;
        cq <= q_in;
      end
      qppg_pkg::OP_CSTORE: begin
        s1 <= sin_m[31:0];
        c1 <= cos_m[31:0];
      end
      qppg_pkg::OP_SCALE: begin
        if (wb_en) begin
          case (wj[1:0])
            2'd0:    vx0 <= pr30;
            2'd1:    vy0 <= pr30;
            2'd2:    vx1 <= pr30;
            default: vy1 <= pr30;
          endcase
        end
      end
      qppg_pkg::OP_COEF: begin
        a3x <= qppg_pkg::A3_D * dx + qppg_pkg::A3_V0 * vx0 + qppg_pkg::A3_V1 * vx1;
        a4x <= qppg_pkg::A4_D * dx + qppg_pkg::A4_V0 * vx0 + qppg_pkg::A4_V1 * vx1;
        a5x <= qppg_pkg::A5_D * dx + qppg_pkg::A5_V0 * vx0 + qppg_pkg::A5_V1 * vx1;
        a3y <= qppg_pkg::A3_D * dy + qppg_pkg::A3_V0 * vy0 + qppg_pkg::A3_V1 * vy1;
        a4y <= qppg_pkg::A4_D * dy + qppg_pkg::A4_V0 * vy0 + qppg_pkg::A4_V1 * vy1;
        a5y <= qppg_pkg::A5_D * dy + qppg_pkg::A5_V0 * vy0 + qppg_pkg::A5_V1 * vy1;
        dr  <= '0;
        dq  <= '0;
        t   <= '0;
        r   <= n >> 1;
        i   <= '0;
      end
      qppg_pkg::OP_DIV: begin
        dr   <= dge ? SW'(dsh - {1'b0, n}) : dsh[SW-1:0];
        dq   <= {dq[TW-2:0], dge};
        accx <= a5x;
        accy <= a5y;
      end
      qppg_pkg::OP_HORNER: begin
        if (wb_en) begin
          if (wj[0]) begin
            accy <= addy + pr24;
          end else begin
            accx <= addx + pr24;
          end
        end
      end
      qppg_pkg::OP_EMIT: begin
        point_x     <= satx[31:0];
        point_y     <= saty[31:0];
        point_index <= idx_w[5:0];
        last_point  <= st.is_last;
        accx        <= a5x;
        accy        <= a5y;
        r           <= rge ? SW'(rsum - {1'b0, n}) : rsum[SW-1:0];
        t           <= t + dq + TW'(rge);
        i           <= i + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: test/qppg_checker.sv
`timescale 1ns / 100ps

module qppg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic [15:0]        start_heading,
  input  logic [15:0]        end_heading,
  input  logic signed [31:0] start_slope,
  input  logic signed [31:0] end_slope,
  input  logic [5:0]         steps,
  input  logic               include_end,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [5:0]         point_index,
  input  logic               last_point,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [5:0]         idx;
    logic               last;
  } point_t;

  point_t points_due[$];

  localparam longint GAIN_INV = 64'sd652032874;

  // floor division by a power of two on signed 64-bit values
  function automatic longint fshr(input longint v, input int s);
    return v >>> s;
  endfunction

  // sine and cosine of a heading in Q2.30
  function automatic void heading_trig(input logic [15:0] hd, output longint sn,
                                       output longint cs);
    logic [31:0] a, u;
    logic [1:0]  q;
    longint      x, y, z, dx, dy;
    a = {hd, 16'd0};
    q = 2'((a + 32'h2000_0000) >> 30);
    u = a - ({30'd0, q} << 30);
    z = longint'($signed(u));
    x = GAIN_INV;
    y = 0;
    for (int k = 0; k < 24; k++) begin
      dx = fshr(y, k);
      dy = fshr(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(qppg_pkg::atan_turn(5'(k)));
      end else begin
        x += dx; y -= dy; z += longint'(qppg_pkg::atan_turn(5'(k)));
      end
    end
    case (q)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic longint slope_part(input longint sl, input longint tr);
    return fshr(sl * tr + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint mul_t(input longint acc, input longint t);
    return fshr(acc * t + (64'sd1 <<< 23), 24);
  endfunction

  // one axis of the quintic, saturated to 32 bits
  function automatic logic signed [31:0] axis_value(input longint p0, input longint p1,
      input longint v0, input longint v1, input longint t);
    longint d, a3, a4, a5, acc;
    d  = p1 - p0;
    a3 = 10 * d - 6 * v0 - 4 * v1;
    a4 = -15 * d + 8 * v0 + 7 * v1;
    a5 = 6 * d - 3 * v0 - 3 * v1;
    acc = a4 + mul_t(a5, t);
    acc = a3 + mul_t(acc, t);
    acc = mul_t(acc, t);
    acc = v0 + mul_t(acc, t);
    acc = p0 + mul_t(acc, t);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return 32'(acc);
  endfunction

  // expand one segment transaction into its points
  task automatic predict_segment();
    longint s0, c0, s1, c1, vx0, vy0, vx1, vy1, n, lst, t;
    point_t p;
    n = longint'(steps);
    if (n == 0) n = 1;
    if (n > 63) n = 63;
    lst = include_end ? n : n - 1;
    heading_trig(start_heading, s0, c0);
    heading_trig(end_heading, s1, c1);
    vx0 = slope_part(start_slope, s0);
    vy0 = slope_part(start_slope, c0);
    vx1 = slope_part(end_slope, s1);
    vy1 = slope_part(end_slope, c1);
    for (longint i = 0; i <= lst; i++) begin
      t = ((i <<< 24) + n / 2) / n;
      p.px   = axis_value(start_x, end_x, vx0, vx1, t);
      p.py   = axis_value(start_y, end_y, vy0, vy1, t);
      p.idx  = 6'(i);
      p.last = (i == lst);
      points_due.push_back(p);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = points_due.size();

  // watch both channels
  always @(posedge clk) begin
    point_t e;
    if (!rst) begin
      if (in_valid && !in_stall) predict_segment();
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          report("unexpected point, index", point_index, 0);
        end else begin
          e = points_due.pop_front();
          if (point_x !== e.px) report("point_x", point_x, e.px);
          if (point_y !== e.py) report("point_y", point_y, e.py);
          if (point_index !== e.idx) report("point_index", point_index, e.idx);
          if (last_point !== e.last) report("last_point", last_point, e.last);
        end
      end
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
  logic [15:0]        start_heading = 0, end_heading = 0;
  logic signed [31:0] start_slope = 0, end_slope = 0;
  logic [5:0]         steps = 1;
  logic               include_end = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] point_x, point_y;
  logic [5:0]         point_index;
  logic               last_point;
  int                 errors, pending;
  int                 cycles = 0;
  int                 sent = 0;
  bit                 calm = 0;
  bit                 hold_long = 0;

  localparam int N_DIRECTED = 20;
  localparam int N_TOTAL    = 270;
  localparam int CYCLE_LIMIT = 2_000_000;

  quintic_path_point_generator u_dut (.*);

  qppg_checker u_chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // drive one segment transaction and wait for acceptance
  task automatic send_segment(input logic [31:0] sx, sy, ex, ey, input logic [15:0] h0, h1,
                              input logic [31:0] s0, s1, input logic [5:0] n,
                              input logic ie);
    start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
    start_heading <= h0; end_heading <= h1;
    start_slope <= s0; end_slope <= s1;
    steps <= n; include_end <= ie;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // sender: directed, then random, with idle bursts
  initial begin : stimulus
    logic [5:0] n;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_segment(0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    send_segment(0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
    send_segment(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 16'h0000, 16'hffff, 32'h7fff_ffff, 32'h8000_0000, 63, 1);
    send_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 16'hffff, 16'h8000, 32'h8000_0000, 32'h7fff_ffff, 63, 0);
    send_segment(0, 0, 32'h0010_0000, 32'h0020_0000, 16'h4000, 16'hc000,
                 32'h0001_0000, 32'h0002_0000, 7, 1);
    send_segment(0, 0, 32'h0010_0000, 0, 16'h2000, 16'h6000, 32'h0050_0000,
                 32'h0050_0000, 4, 1);
    send_segment(32'hfff0_0000, 0, 0, 32'hfff0_0000, 16'ha000, 16'he000,
                 32'hffff_0000, 32'h0003_0000, 0, 1);
    send_segment(0, 0, 0, 0, 16'h1fff, 16'h2000, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
    send_segment(0, 0, 0, 0, 16'h5fff, 16'h6000, 32'h8000_0000, 32'h8000_0000, 2, 0);
    send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 16'h8000, 16'h4000, 32'h7fff_ffff, 32'h7fff_ffff, 5, 1);
    send_segment(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h5555_aaaa, 16'haaaa,
                 16'h5555, 32'h0000_8000, 32'hffff_8000, 62, 1);
    send_segment(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                 16'h0001, 16'hfffe, 32'h5555_5555, 32'haaaa_aaaa, 6'h2a, 0);
    send_segment(0, 0, 0, 0, 16'h3000, 16'h9000, 32'h0001_0000, 32'h0001_0000, 6'h15, 1);
    while (sent < N_DIRECTED) begin
      send_segment(pick_word(), pick_word(), pick_word(), pick_word(), 16'($urandom),
                   16'($urandom), pick_word(), pick_word(), 6'($urandom),
                   1'($urandom));
    end
    while (sent < N_TOTAL) begin
      if (sent > N_TOTAL - 30) calm = 1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      n = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
      send_segment(pick_word(), pick_word(), pick_word(), pick_word(), 16'($urandom),
                   16'($urandom), pick_word(), pick_word(), n, 1'($urandom));
    end
    in_valid <= 0;
  end

  // receiver stalls, with one long hold-off
  initial begin : receiver
    @(negedge rst);
    while (!calm) begin
      @(posedge clk);
      if (!hold_long && sent >= 40) begin
        hold_long = 1;
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        out_stall <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 0;
      end
    end
    out_stall <= 0;
  end

  // verdict and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : verdict
    wait (sent == N_TOTAL);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: quintic_path_point_generator.f
rtl/qppg_pkg.sv
rtl/qppg_ctrl.sv
rtl/qppg_datapath.sv
rtl/quintic_path_point_generator.sv
test/qppg_checker.sv
test/tb.sv
